[src/pcpq_pkg.sv]
// Shared types for the polyline closest point query unit.
package pcpq_pkg;

   // Datapath step selected by the controller.
   typedef enum logic [4:0] {
      DP_IDLE,
      DP_CHECK,
      DP_RD_A,
      DP_RD_B,
      DP_DIFF,
      DP_M_LX,
      DP_M_LZ,
      DP_M_DX,
      DP_M_DZ,
      DP_DOT,
      DP_CLASS,
      DP_DIV,
      DP_I_X,
      DP_I_Y,
      DP_I_Z,
      DP_I_END,
      DP_D_Z,
      DP_D_SUM,
      DP_CMP,
      DP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      load;     // write the vertex on the request word
      logic      capture;  // latch a query request word
   } ctrl_cmd_type;

   typedef struct packed {
      logic empty;     // no segment to examine
      logic need_div;  // projection factor strictly inside 0..1
      logic div_last;  // last quotient bit this cycle
      logic seg_last;  // current segment is the window end
      logic out_free;  // result register can take a word
   } dp_status_type;

   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

endpackage

[src/polyline_closest_point_query_unit.sv]
// Nearest point on a stored polyline: load words write vertices; a query word
// walks its clamped segment window one segment at a time. Each segment uses
// one shared 33x33 multiplier and a bit-serial projection divide; a segment
// whose factor clamps to 0 or 1 skips the divide. A query with too few points
// or an empty window goes straight to its result. The input is ready for the
// next word in the same cycle that the result becomes valid.
// Queries are processed one at a time; a finished result waits in an output
// register without blocking the next request word, but the next result waits
// until that register is taken.
module polyline_closest_point_query_unit import pcpq_pkg::*; #(
   parameter int MAX_POINTS = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [8:0]   csr_wr_data,    // point_count
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [119:0] req_tdata,      // vertex_index, coord_x, coord_y, coord_z,
                                        // first_segment, last_segment
   input  logic         req_tuser,      // kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [167:0] rsp_tdata,      // segment, distance_squared, point_x,
                                        // point_y, point_z
   output logic         rsp_tuser       // found
);

   logic [8:0]    point_count_ff;
   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic [7:0]    rsp_segment;
   logic [63:0]   rsp_distance_squared;
   logic [31:0]   rsp_point_x, rsp_point_y, rsp_point_z;

   // Hold point count register
   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= 9'd0;
      end else if (csr_wr_en) begin
         point_count_ff <= csr_wr_data;
      end
   end

   pcpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pcpq_datapath #(.MAX_POINTS(MAX_POINTS)) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .vertex_index         (req_tdata[7:0]),
      .coord_x              (req_tdata[39:8]),
      .coord_y              (req_tdata[71:40]),
      .coord_z              (req_tdata[103:72]),
      .first_segment        (req_tdata[111:104]),
      .last_segment         (req_tdata[119:112]),
      .point_count          (point_count_ff),
      .rsp_ready            (rsp_tready),
      .rsp_valid            (rsp_tvalid),
      .rsp_found            (rsp_tuser),
      .rsp_segment          (rsp_segment),
      .rsp_distance_squared (rsp_distance_squared),
      .rsp_point_x          (rsp_point_x),
      .rsp_point_y          (rsp_point_y),
      .rsp_point_z          (rsp_point_z)
   );

   assign rsp_tdata = {rsp_point_z, rsp_point_y, rsp_point_x,
                       rsp_distance_squared, rsp_segment};

endmodule

[src/pcpq_ctrl.sv]
// Controller state machine sequencing the query datapath.
module pcpq_ctrl import pcpq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_kind,
   output logic          req_tready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_CHECK, ST_RD_A, ST_RD_B, ST_DIFF, ST_M_LX, ST_M_LZ, ST_M_DX,
      ST_M_DZ, ST_DOT, ST_CLASS, ST_DIV, ST_I_X, ST_I_Y, ST_I_Z, ST_I_END,
      ST_D_Z, ST_D_SUM, ST_CMP, ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_tvalid && req_kind) state_in = ST_CHECK;
         ST_CHECK: state_in = status.empty ? ST_EMIT : ST_RD_A;
         ST_RD_A:  state_in = ST_RD_B;
         ST_RD_B:  state_in = ST_DIFF;
         ST_DIFF:  state_in = ST_M_LX;
         ST_M_LX:  state_in = ST_M_LZ;
         ST_M_LZ:  state_in = ST_M_DX;
         ST_M_DX:  state_in = ST_M_DZ;
         ST_M_DZ:  state_in = ST_DOT;
         ST_DOT:   state_in = ST_CLASS;
         ST_CLASS: state_in = status.need_div ? ST_DIV : ST_I_X;
         ST_DIV:   if (status.div_last) state_in = ST_I_X;
         ST_I_X:   state_in = ST_I_Y;
         ST_I_Y:   state_in = ST_I_Z;
         ST_I_Z:   state_in = ST_I_END;
         ST_I_END: state_in = ST_D_Z;
         ST_D_Z:   state_in = ST_D_SUM;
         ST_D_SUM: state_in = ST_CMP;
         ST_CMP:   state_in = status.seg_last ? ST_EMIT : ST_RD_A;
         ST_EMIT:  if (status.out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Decode step command
   always_comb begin
      cmd.load    = (state_ff == ST_IDLE) && req_tvalid && !req_kind;
      cmd.capture = (state_ff == ST_IDLE) && req_tvalid && req_kind;
      case (state_ff)
         ST_IDLE:  cmd.op = DP_IDLE;
         ST_CHECK: cmd.op = DP_CHECK;
         ST_RD_A:  cmd.op = DP_RD_A;
         ST_RD_B:  cmd.op = DP_RD_B;
         ST_DIFF:  cmd.op = DP_DIFF;
         ST_M_LX:  cmd.op = DP_M_LX;
         ST_M_LZ:  cmd.op = DP_M_LZ;
         ST_M_DX:  cmd.op = DP_M_DX;
         ST_M_DZ:  cmd.op = DP_M_DZ;
         ST_DOT:   cmd.op = DP_DOT;
         ST_CLASS: cmd.op = DP_CLASS;
         ST_DIV:   cmd.op = DP_DIV;
         ST_I_X:   cmd.op = DP_I_X;
         ST_I_Y:   cmd.op = DP_I_Y;
         ST_I_Z:   cmd.op = DP_I_Z;
         ST_I_END: cmd.op = DP_I_END;
         ST_D_Z:   cmd.op = DP_D_Z;
         ST_D_SUM: cmd.op = DP_D_SUM;
         ST_CMP:   cmd.op = DP_CMP;
         ST_EMIT:  cmd.op = DP_EMIT;
         default:  cmd.op = DP_IDLE;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

[src/pcpq_datapath.sv]
// Vertex memories, shared multiplier, divider and best-segment registers.
module pcpq_datapath import pcpq_pkg::*; #(
   parameter int MAX_POINTS = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output dp_status_type       status,
   input  logic [7:0]          vertex_index,
   input  logic signed [31:0]  coord_x,
   input  logic signed [31:0]  coord_y,
   input  logic signed [31:0]  coord_z,
   input  logic [7:0]          first_segment,
   input  logic [7:0]          last_segment,
   input  logic [8:0]          point_count,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic                rsp_found,
   output logic [7:0]          rsp_segment,
   output logic [63:0]         rsp_distance_squared,
   output logic [31:0]         rsp_point_x,
   output logic [31:0]         rsp_point_y,
   output logic [31:0]         rsp_point_z
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int IW = (AW + 1 > 9) ? AW + 1 : 9;

   logic [31:0] mem_x [MAX_POINTS];
   logic [31:0] mem_y [MAX_POINTS];
   logic [31:0] mem_z [MAX_POINTS];
   logic [31:0] rd_x_ff, rd_y_ff, rd_z_ff;

   logic [31:0] q_x_ff, q_z_ff;
   logic [7:0]  last_ff, seg_ff;
   logic        empty_ff;
   logic [31:0] a_x_ff, a_y_ff, a_z_ff;
   logic signed [32:0] s_x_ff, s_y_ff, s_z_ff, e_x_ff, e_z_ff;
   logic [65:0] prod_ff;
   logic        neg_ff;
   logic [66:0] len2_ff;
   logic signed [67:0] dot_ff;
   logic [32:0] alpha_ff;
   logic [66:0] rem_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [31:0] p_x_ff, p_y_ff, p_z_ff;
   logic [66:0] dsum_ff;
   logic        best_found_ff;
   logic [7:0]  best_seg_ff;
   logic [63:0] best_d_ff;
   logic [31:0] best_x_ff, best_y_ff, best_z_ff;
   logic        out_valid_ff;

   function automatic logic [32:0] mag33(input logic signed [32:0] v);
      mag33 = v[32] ? 33'(-v) : 33'(v);
   endfunction

   // base + floor(delta * alpha / 2^32), product given as magnitude and sign
   function automatic logic [31:0] interp(input logic [31:0] base,
                                          input logic [65:0] p, input logic neg);
      logic [33:0] b34;
      logic [33:0] q;
      logic [33:0] r;
      b34 = {{2{base[31]}}, base};
      q   = p[65:32];
      if (neg) begin
         r = b34 - q - 34'(p[31:0] != 32'd0);
      end else begin
         r = b34 + q;
      end
      interp = r[31:0];
   endfunction

   // Window clamp
   logic [IW-1:0] cnt_w, maxseg_w;
   logic [7:0]    first_c, last_c;
   always_comb begin
      cnt_w    = (IW'(point_count) > IW'(MAX_POINTS)) ? IW'(MAX_POINTS) : IW'(point_count);
      maxseg_w = cnt_w - IW'(2);
      first_c  = (IW'(first_segment) > maxseg_w) ? maxseg_w[7:0] : first_segment;
      last_c   = (IW'(last_segment) > maxseg_w) ? maxseg_w[7:0] : last_segment;
   end

   // Memory write and read
   logic [IW-1:0] wr_addr, rd_addr;
   assign wr_addr = IW'(vertex_index);
   assign rd_addr = (cmd.op == DP_RD_B) ? IW'(seg_ff) + IW'(1) : IW'(seg_ff);

   always_ff @(posedge clock) begin
      if (cmd.load && (wr_addr < IW'(MAX_POINTS))) begin
         mem_x[wr_addr[AW-1:0]] <= coord_x;
         mem_y[wr_addr[AW-1:0]] <= coord_y;
         mem_z[wr_addr[AW-1:0]] <= coord_z;
      end
      rd_x_ff <= mem_x[rd_addr[AW-1:0]];
      rd_y_ff <= mem_y[rd_addr[AW-1:0]];
      rd_z_ff <= mem_z[rd_addr[AW-1:0]];
   end

   // Shared multiplier operand select
   logic [32:0] mul_a, mul_b;
   logic        mul_neg;
   logic signed [32:0] dx_w, dz_w;
   assign dx_w = {q_x_ff[31], q_x_ff} - {p_x_ff[31], p_x_ff};
   assign dz_w = {q_z_ff[31], q_z_ff} - {p_z_ff[31], p_z_ff};
   always_comb begin
      mul_a   = mag33(s_x_ff);
      mul_b   = mag33(s_x_ff);
      mul_neg = 1'b0;
      case (cmd.op)
         DP_M_LZ: begin
            mul_a = mag33(s_z_ff);
            mul_b = mag33(s_z_ff);
         end
         DP_M_DX: begin
            mul_a   = mag33(e_x_ff);
            mul_neg = e_x_ff[32] ^ s_x_ff[32];
         end
         DP_M_DZ: begin
            mul_a   = mag33(e_z_ff);
            mul_b   = mag33(s_z_ff);
            mul_neg = e_z_ff[32] ^ s_z_ff[32];
         end
         DP_I_X: begin
            mul_b   = alpha_ff;
            mul_neg = s_x_ff[32];
         end
         DP_I_Y: begin
            mul_a   = mag33(s_y_ff);
            mul_b   = alpha_ff;
            mul_neg = s_y_ff[32];
         end
         DP_I_Z: begin
            mul_a   = mag33(s_z_ff);
            mul_b   = alpha_ff;
            mul_neg = s_z_ff[32];
         end
         DP_I_END: begin
            mul_a = mag33(dx_w);
            mul_b = mag33(dx_w);
         end
         DP_D_Z: begin
            mul_a = mag33(dz_w);
            mul_b = mag33(dz_w);
         end
         default: begin
            mul_neg = 1'b0;
         end
      endcase
   end

   logic signed [67:0] sprod;
   assign sprod = neg_ff ? -$signed({2'b00, prod_ff}) : $signed({2'b00, prod_ff});

   logic        dot_pos, dot_ge;
   logic [67:0] r2;
   logic        r2_ge;
   logic [63:0] d_sat;
   assign dot_pos = !dot_ff[67] && (dot_ff != 68'sd0);
   assign dot_ge  = dot_ff[66:0] >= len2_ff;
   assign r2      = {rem_ff, 1'b0};
   assign r2_ge   = r2 >= {1'b0, len2_ff};
   assign d_sat   = (dsum_ff[66:64] != 3'd0) ? {64{1'b1}} : dsum_ff[63:0];

   // Per-segment datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      neg_ff  <= mul_neg;
      if (cmd.capture) begin
         q_x_ff   <= coord_x;
         q_z_ff   <= coord_z;
         last_ff  <= last_c;
         seg_ff   <= first_c;
         empty_ff <= (cnt_w < IW'(2)) || (first_c > last_c);
      end
      case (cmd.op)
         DP_RD_B: begin
            a_x_ff <= rd_x_ff;
            a_y_ff <= rd_y_ff;
            a_z_ff <= rd_z_ff;
         end
         DP_DIFF: begin
            s_x_ff <= {rd_x_ff[31], rd_x_ff} - {a_x_ff[31], a_x_ff};
            s_y_ff <= {rd_y_ff[31], rd_y_ff} - {a_y_ff[31], a_y_ff};
            s_z_ff <= {rd_z_ff[31], rd_z_ff} - {a_z_ff[31], a_z_ff};
            e_x_ff <= {q_x_ff[31], q_x_ff} - {a_x_ff[31], a_x_ff};
            e_z_ff <= {q_z_ff[31], q_z_ff} - {a_z_ff[31], a_z_ff};
         end
         DP_M_LZ: len2_ff <= {1'b0, prod_ff};
         DP_M_DX: len2_ff <= len2_ff + {1'b0, prod_ff};
         DP_M_DZ: dot_ff <= sprod;
         DP_DOT: begin
            dot_ff <= dot_ff + sprod;
            if (len2_ff == 67'd0) len2_ff <= 67'd1;
         end
         DP_CLASS: begin
            alpha_ff   <= (dot_pos && dot_ge) ? {1'b1, 32'd0} : 33'd0;
            rem_ff     <= dot_ff[66:0];
            div_cnt_ff <= '0;
         end
         DP_DIV: begin
            rem_ff     <= r2_ge ? 67'(r2 - {1'b0, len2_ff}) : r2[66:0];
            alpha_ff   <= {alpha_ff[31:0], r2_ge};
            div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
         end
         DP_I_Y:   p_x_ff <= interp(a_x_ff, prod_ff, neg_ff);
         DP_I_Z:   p_y_ff <= interp(a_y_ff, prod_ff, neg_ff);
         DP_I_END: p_z_ff <= interp(a_z_ff, prod_ff, neg_ff);
         DP_D_Z:   dsum_ff <= {1'b0, prod_ff};
         DP_D_SUM: dsum_ff <= dsum_ff + {1'b0, prod_ff};
         DP_CMP:   seg_ff <= seg_ff + 8'd1;
         default: begin
         end
      endcase
   end

   // Keep the strictly nearest segment
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         best_found_ff <= 1'b0;
         best_seg_ff   <= 8'd0;
         best_d_ff     <= 64'd0;
         best_x_ff     <= 32'd0;
         best_y_ff     <= 32'd0;
         best_z_ff     <= 32'd0;
      end else if (cmd.op == DP_CMP && (!best_found_ff || d_sat < best_d_ff)) begin
         best_found_ff <= 1'b1;
         best_seg_ff   <= seg_ff;
         best_d_ff     <= d_sat;
         best_x_ff     <= p_x_ff;
         best_y_ff     <= p_y_ff;
         best_z_ff     <= p_z_ff;
      end
   end

   // Result register
   logic out_free;
   assign out_free = !out_valid_ff || rsp_ready;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.op == DP_EMIT && out_free) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == DP_EMIT && out_free) begin
         rsp_found            <= best_found_ff;
         rsp_segment          <= best_seg_ff;
         rsp_distance_squared <= best_d_ff;
         rsp_point_x          <= best_x_ff;
         rsp_point_y          <= best_y_ff;
         rsp_point_z          <= best_z_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign status.empty    = empty_ff;
   assign status.need_div = dot_pos && !dot_ge;
   assign status.div_last = (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));
   assign status.seg_last = (seg_ff == last_ff);
   assign status.out_free = out_free;

endmodule

[src/pcpq_checker.sv]
// Port-level checks for the polyline closest point query unit.
module pcpq_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [167:0] rsp_tdata,
   input logic         rsp_tuser
);

   // No result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Stalled result word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // A miss carries all-zero payload
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 168'd0)
      else $error("miss with nonzero payload");

   // A query word blocks the input while it is worked on
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> !req_tready)
      else $error("input ready during a query");

endmodule

bind polyline_closest_point_query_unit pcpq_checker u_pcpq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
